// ----- rtl/core/sap_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sap_pkg;

  localparam int unsigned DimBits  = 9;
  localparam int unsigned PosBits  = 12;
  localparam int unsigned GapBits  = 6;
  localparam int unsigned QryBits  = 8;
  localparam int unsigned CodeBits = 3;
  localparam int unsigned SumBits  = 14;
  localparam logic [CodeBits-1:0] LastCode = 3'd4;
  localparam logic [GapBits-1:0]  GapReset = 6'd4;
  localparam logic [12:0]         BaseSide = 13'd256;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADQRY  = 2'd3
  } status_e;

  typedef struct packed {
    logic               action;
    logic [DimBits-1:0] rect_width;
    logic [DimBits-1:0] rect_height;
    logic               last_rect;
    logic [QryBits-1:0] query_index;
  } item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [CodeBits-1:0] size_code;
    logic [PosBits-1:0]  place_x;
    logic [PosBits-1:0]  place_y;
  } result_t;

  typedef struct packed {
    logic init;
    logic line_break;
    logic place;
  } shelf_ctl_t;

  typedef struct packed {
    logic too_wide;
    logic need_break;
    logic too_tall;
  } shelf_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QRD,
    S_KEY,
    S_KEYW,
    S_SCAN,
    S_CMP,
    S_SWR,
    S_PINIT,
    S_PRD,
    S_PRD2,
    S_PEV,
    S_PPL
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/core/sap_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sap_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/core/sap_shelf.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sap_shelf (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sap_pkg::shelf_ctl_t           ctl_i,
  input  wire logic [sap_pkg::GapBits-1:0]   gap_i,
  input  wire logic [12:0]                   side_i,
  input  wire logic [sap_pkg::DimBits-1:0]   w_i,
  input  wire logic [sap_pkg::DimBits-1:0]   h_i,
  output sap_pkg::shelf_sts_t                sts_o,
  output logic      [sap_pkg::PosBits-1:0]   pen_x_o,
  output logic      [sap_pkg::PosBits-1:0]   pen_y_o
);
  import sap_pkg::*;

  logic [SumBits-1:0] pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  logic [DimBits-1:0] shelf_q, shelf_d;
  logic [SumBits-1:0] gap_w, w_w, h_w, side_w;

  assign gap_w  = SumBits'(gap_i);
  assign w_w    = SumBits'(w_i);
  assign h_w    = SumBits'(h_i);
  assign side_w = SumBits'(side_i);

  assign sts_o.too_wide   = (w_w + gap_w + gap_w) > side_w;
  assign sts_o.need_break = (pen_x_q + w_w + gap_w) > side_w;
  assign sts_o.too_tall   = (pen_y_q + h_w + gap_w) > side_w;
  assign pen_x_o = pen_x_q[PosBits-1:0];
  assign pen_y_o = pen_y_q[PosBits-1:0];

  always_comb begin
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    shelf_d = shelf_q;
    if (ctl_i.init) begin
      pen_x_d = gap_w;
      pen_y_d = gap_w;
      shelf_d = '0;
    end else if (ctl_i.line_break) begin
      pen_y_d = pen_y_q + SumBits'(shelf_q) + gap_w;
      pen_x_d = gap_w;
      shelf_d = '0;
    end else if (ctl_i.place) begin
      pen_x_d = pen_x_q + w_w + gap_w;
      if (h_i > shelf_q) begin
        shelf_d = h_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
      shelf_q <= '0;
    end else begin
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
      shelf_q <= shelf_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/shelf_atlas_packer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// shelf atlas packer
// item channel: start_i with item_i, taken when start_i is high and busy_o low.
// a load stores one rectangle; a query reads a placement by load index.
// result channel: result_valid_o strobes one cycle with result_o, one result
// per item. the receiver cannot stall, so no result is ever held back.
// a plain load or a rejected query answers in the next cycle, a good query
// after the position read in S_QRD. the load marked last, if stored, runs the
// stable height sort, then shelf placement at sides 256 up to 4096. the sort
// ranks each rectangle against all others through the single height memory
// read port. each shelf pass steps every rectangle through S_PRD, S_PRD2,
// S_PEV and S_PPL (an empty one skips S_PPL), up to five passes. busy_o stays
// high for the whole pack. gap is written through cfg_we_i / cfg_wdata_i; the
// user must write it only while idle, the block does not enforce it; reset
// value 4. reset clears the count, the packed flag and the sequencer; the
// stores need no clearing since no entry is read before written.
module shelf_atlas_packer_core #(
  parameter int unsigned MAX_RECTS = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire sap_pkg::item_t              item_i,
  output logic                             busy_o,
  output logic                             result_valid_o,
  output sap_pkg::result_t                 result_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [sap_pkg::GapBits-1:0] cfg_wdata_i
);
  import sap_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_RECTS);
  localparam int unsigned CntW = $clog2(MAX_RECTS + 1);
  localparam int unsigned QW   = (CntW > QryBits) ? CntW : QryBits;

  state_e state_q, state_d;
  logic [GapBits-1:0]  gap_q;
  logic [CntW-1:0]     cnt_q, cnt_d, i_q, i_d, j_q, j_d, rank_q, rank_d, k_q, k_d;
  logic [DimBits-1:0]  hi_q, hi_d;
  logic [IdxW-1:0]     r_q, r_d;
  logic [CodeBits-1:0] s_q, s_d, code_q, code_d;
  logic                pv_q, pv_d;
  logic                rv_q, rv_d;
  result_t             res_q, res_d;

  logic [CntW-1:0]     cnt_eff;
  logic                wh_we;
  logic [IdxW-1:0]     h_raddr, w_raddr;
  logic [DimBits-1:0]  h_rdata, w_rdata;
  logic                so_we;
  logic [IdxW-1:0]     so_rdata;
  logic                pos_we;
  logic [PosBits-1:0]  pos_x_wd, pos_y_wd, pos_x_rd, pos_y_rd;
  logic [IdxW-1:0]     pos_raddr;
  shelf_ctl_t          sctl;
  shelf_sts_t          ssts;
  logic [PosBits-1:0]  pen_x, pen_y;
  logic [12:0]         side;
  logic                accept, is_load, qry_ok, zero_rect;

  assign accept    = start_i && (state_q == S_IDLE);
  assign is_load   = (item_i.action == ACT_LOAD);
  assign cnt_eff   = pv_q ? '0 : cnt_q;
  assign qry_ok    = pv_q && (QW'(item_i.query_index) < QW'(cnt_q));
  assign side      = BaseSide << s_q;
  assign zero_rect = (w_rdata == '0) || (h_rdata == '0);
  assign pos_raddr = IdxW'(item_i.query_index);

  sap_ram #(.Width(DimBits), .Depth(MAX_RECTS)) u_width_ram (
    .clk_i, .we_i(wh_we), .waddr_i(cnt_eff[IdxW-1:0]), .wdata_i(item_i.rect_width),
    .raddr_i(w_raddr), .rdata_o(w_rdata)
  );
  sap_ram #(.Width(DimBits), .Depth(MAX_RECTS)) u_height_ram (
    .clk_i, .we_i(wh_we), .waddr_i(cnt_eff[IdxW-1:0]), .wdata_i(item_i.rect_height),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );
  sap_ram #(.Width(IdxW), .Depth(MAX_RECTS)) u_order_ram (
    .clk_i, .we_i(so_we), .waddr_i(rank_q[IdxW-1:0]), .wdata_i(i_q[IdxW-1:0]),
    .raddr_i(k_q[IdxW-1:0]), .rdata_o(so_rdata)
  );
  sap_ram #(.Width(PosBits), .Depth(MAX_RECTS)) u_pos_x_ram (
    .clk_i, .we_i(pos_we), .waddr_i(r_q), .wdata_i(pos_x_wd),
    .raddr_i(pos_raddr), .rdata_o(pos_x_rd)
  );
  sap_ram #(.Width(PosBits), .Depth(MAX_RECTS)) u_pos_y_ram (
    .clk_i, .we_i(pos_we), .waddr_i(r_q), .wdata_i(pos_y_wd),
    .raddr_i(pos_raddr), .rdata_o(pos_y_rd)
  );

  sap_shelf u_shelf (
    .clk_i, .rst_ni, .ctl_i(sctl), .gap_i(gap_q), .side_i(side),
    .w_i(w_rdata), .h_i(h_rdata), .sts_o(ssts), .pen_x_o(pen_x), .pen_y_o(pen_y)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!is_load) begin
            if (qry_ok) state_d = S_QRD;
          end else if ((cnt_eff != CntW'(MAX_RECTS)) && item_i.last_rect) begin
            state_d = S_KEY;
          end
        end
      end
      S_QRD:   state_d = S_IDLE;
      S_KEY:   state_d = S_KEYW;
      S_KEYW:  state_d = S_SCAN;
      S_SCAN:  state_d = S_CMP;
      S_CMP:   state_d = (j_q + 1'b1 == cnt_q) ? S_SWR : S_SCAN;
      S_SWR:   state_d = (i_q + 1'b1 == cnt_q) ? S_PINIT : S_KEY;
      S_PINIT: state_d = S_PRD;
      S_PRD:   state_d = (k_q == cnt_q) ? S_IDLE : S_PRD2;
      S_PRD2:  state_d = S_PEV;
      S_PEV: begin
        if (zero_rect) state_d = S_PRD;
        else if (ssts.too_wide) state_d = (s_q == LastCode) ? S_IDLE : S_PINIT;
        else state_d = S_PPL;
      end
      S_PPL: begin
        if (ssts.too_tall) state_d = (s_q == LastCode) ? S_IDLE : S_PINIT;
        else state_d = S_PRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d   = cnt_q;
    i_d     = i_q;
    j_d     = j_q;
    rank_d  = rank_q;
    k_d     = k_q;
    hi_d    = hi_q;
    r_d     = r_q;
    s_d     = s_q;
    code_d  = code_q;
    pv_d    = pv_q;
    rv_d    = 1'b0;
    res_d   = '0;
    wh_we   = 1'b0;
    so_we   = 1'b0;
    pos_we  = 1'b0;
    pos_x_wd = pen_x;
    pos_y_wd = pen_y;
    sctl    = '0;
    h_raddr = r_q;
    w_raddr = r_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_load) begin
            pv_d  = 1'b0;
            cnt_d = cnt_eff;
            if (cnt_eff == CntW'(MAX_RECTS)) begin
              rv_d         = 1'b1;
              res_d.status = ST_FULL;
            end else begin
              wh_we = 1'b1;
              cnt_d = cnt_eff + 1'b1;
              i_d   = '0;
              if (!item_i.last_rect) rv_d = 1'b1;
            end
          end else if (!qry_ok) begin
            rv_d         = 1'b1;
            res_d.status = ST_BADQRY;
          end
        end
      end
      S_QRD: begin
        rv_d            = 1'b1;
        res_d.size_code = code_q;
        res_d.place_x   = pos_x_rd;
        res_d.place_y   = pos_y_rd;
      end
      S_KEY: h_raddr = i_q[IdxW-1:0];
      S_KEYW: begin
        hi_d   = h_rdata;
        j_d    = '0;
        rank_d = '0;
      end
      S_SCAN: h_raddr = j_q[IdxW-1:0];
      S_CMP: begin
        if ((h_rdata > hi_q) || ((h_rdata == hi_q) && (j_q < i_q))) rank_d = rank_q + 1'b1;
        j_d = j_q + 1'b1;
      end
      S_SWR: begin
        so_we = 1'b1;
        i_d   = i_q + 1'b1;
        if (i_q + 1'b1 == cnt_q) s_d = '0;
      end
      S_PINIT: begin
        sctl.init = 1'b1;
        k_d       = '0;
      end
      S_PRD: begin
        if (k_q == cnt_q) begin
          pv_d            = 1'b1;
          code_d          = s_q;
          rv_d            = 1'b1;
          res_d.size_code = s_q;
        end
      end
      S_PRD2: begin
        r_d     = so_rdata;
        h_raddr = so_rdata;
        w_raddr = so_rdata;
      end
      S_PEV: begin
        if (zero_rect) begin
          pos_we   = 1'b1;
          pos_x_wd = '0;
          pos_y_wd = '0;
          k_d      = k_q + 1'b1;
        end else if (ssts.too_wide) begin
          s_d = s_q + 1'b1;
          if (s_q == LastCode) begin
            rv_d         = 1'b1;
            res_d.status = ST_NOFIT;
            cnt_d        = '0;
          end
        end else if (ssts.need_break) begin
          sctl.line_break = 1'b1;
        end
      end
      S_PPL: begin
        if (ssts.too_tall) begin
          s_d = s_q + 1'b1;
          if (s_q == LastCode) begin
            rv_d         = 1'b1;
            res_d.status = ST_NOFIT;
            cnt_d        = '0;
          end
        end else begin
          pos_we     = 1'b1;
          sctl.place = 1'b1;
          k_d        = k_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      gap_q   <= GapReset;
      cnt_q   <= '0;
      code_q  <= '0;
      pv_q    <= 1'b0;
      rv_q    <= 1'b0;
      s_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      rank_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) gap_q <= cfg_wdata_i;
      cnt_q   <= cnt_d;
      code_q  <= code_d;
      pv_q    <= pv_d;
      rv_q    <= rv_d;
      s_q     <= s_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    r_q   <= r_d;
    res_q <= res_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign result_o       = res_q;

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import sap_pkg::*;

  localparam int Capacity = 256;
  localparam int StallLimit = 400000;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  item_t item_i = '0;
  logic busy_o;
  logic result_valid_o;
  result_t result_o;
  logic cfg_we_i = 1'b0;
  logic [GapBits-1:0] cfg_wdata_i = '0;

  shelf_atlas_packer_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .item_i(item_i),
    .busy_o(busy_o), .result_valid_o(result_valid_o), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shelf packer mirror
  logic [GapBits-1:0] gap_now;
  logic [DimBits-1:0] wid_mem [Capacity];
  logic [DimBits-1:0] hgt_mem [Capacity];
  int unsigned rank_mem [Capacity];
  logic [PosBits-1:0] xpos_mem [Capacity];
  logic [PosBits-1:0] ypos_mem [Capacity];
  int unsigned n_rects;
  logic [CodeBits-1:0] code_now;
  logic packed_ok;

  result_t pending_q [$];
  int mismatches = 0;
  int idle_pct = 0;
  int sent = 0;
  int quiet_cycles = 0;

  function automatic bit shelf_fits(int unsigned side);
    int unsigned g, px, py, shelf, r, w, h;
    g = gap_now;
    px = g;
    py = g;
    shelf = 0;
    for (int i = 0; i < n_rects; i++) begin
      r = rank_mem[i];
      w = wid_mem[r];
      h = hgt_mem[r];
      if (w == 0 || h == 0) begin
        xpos_mem[r] = '0;
        ypos_mem[r] = '0;
        continue;
      end
      if (w + 2 * g > side) return 1'b0;
      if (px + w + g > side) begin
        py += shelf + g;
        px = g;
        shelf = 0;
      end
      if (py + h + g > side) return 1'b0;
      xpos_mem[r] = px[PosBits-1:0];
      ypos_mem[r] = py[PosBits-1:0];
      px += w + g;
      if (h > shelf) shelf = h;
    end
    return 1'b1;
  endfunction

  function automatic bit pack_set();
    int unsigned key, j;
    for (int i = 0; i < n_rects; i++) rank_mem[i] = i;
    for (int i = 1; i < n_rects; i++) begin
      key = rank_mem[i];
      j = i;
      while (j > 0 && hgt_mem[rank_mem[j-1]] < hgt_mem[key]) begin
        rank_mem[j] = rank_mem[j-1];
        j--;
      end
      rank_mem[j] = key;
    end
    for (int s = 0; s <= LastCode; s++) begin
      if (shelf_fits(int'(BaseSide) << s)) begin
        code_now = s[CodeBits-1:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t res;
    res = '0;
    res.status = ST_OK;
    if (it.action == ACT_LOAD) begin
      if (packed_ok) begin
        packed_ok = 1'b0;
        n_rects = 0;
      end
      if (n_rects >= Capacity) begin
        res.status = ST_FULL;
      end else begin
        wid_mem[n_rects] = it.rect_width;
        hgt_mem[n_rects] = it.rect_height;
        n_rects++;
        if (it.last_rect) begin
          if (pack_set()) begin
            packed_ok = 1'b1;
            res.size_code = code_now;
          end else begin
            res.status = ST_NOFIT;
            n_rects = 0;
          end
        end
      end
    end else if (!packed_ok || it.query_index >= n_rects) begin
      res.status = ST_BADQRY;
    end else begin
      res.size_code = code_now;
      res.place_x = xpos_mem[it.query_index];
      res.place_y = ypos_mem[it.query_index];
    end
    return res;
  endfunction

  function automatic item_t mk(logic act, int w, int h, logic last, int q);
    item_t it;
    it.action = act;
    it.rect_width = w[DimBits-1:0];
    it.rect_height = h[DimBits-1:0];
    it.last_rect = last;
    it.query_index = q[QryBits-1:0];
    return it;
  endfunction

  function automatic result_t res(status_e st, int code, int x, int y);
    result_t r;
    r.status = st;
    r.size_code = code[CodeBits-1:0];
    r.place_x = x[PosBits-1:0];
    r.place_y = y[PosBits-1:0];
    return r;
  endfunction

  task automatic send_item(item_t it, logic typed = 1'b0, result_t want = '0);
    result_t r;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy_o);
    r = predict_result(it);
    pending_q.push_back(typed ? want : r);
    sent++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_gap(int g);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= g[GapBits-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gap_now = g[GapBits-1:0];
  endtask

  function automatic int rand_dim(int mode);
    case (mode)
      0: return $urandom_range(1, 40);
      1: return $urandom_range(0, 511);
      default: return ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 160);
    endcase
  endfunction

  task automatic random_set(int n, int mode);
    int nq;
    for (int i = 0; i < n; i++)
      send_item(mk(ACT_LOAD, rand_dim(mode), rand_dim(mode), i == n - 1,
                   $urandom_range(255)));
    nq = $urandom_range(0, n + 2);
    for (int i = 0; i < nq; i++)
      send_item(mk(ACT_QUERY, $urandom_range(511), $urandom_range(511),
                   1'($urandom_range(1)), ($urandom_range(7) == 0) ?
                   $urandom_range(255) : $urandom_range(0, n + 1)));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (result_valid_o) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", result_o);
        end else begin
          if (result_o !== pending_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", pending_q[0], result_o);
          end
          void'(pending_q.pop_front());
        end
      end
    end
  end

  row_t dir_rows [] = '{
    '{mk(ACT_QUERY, 0, 0, 0, 0), 1'b1, res(ST_BADQRY, 0, 0, 0)},
    '{mk(ACT_LOAD, 0, 0, 1, 0), 1'b1, res(ST_OK, 0, 0, 0)},
    '{mk(ACT_QUERY, 0, 0, 0, 0), 1'b1, res(ST_OK, 0, 0, 0)},
    '{mk(ACT_QUERY, 0, 0, 0, 1), 1'b1, res(ST_BADQRY, 0, 0, 0)},
    '{mk(ACT_LOAD, 511, 511, 1, 255), 1'b1, res(ST_OK, 2, 0, 0)},
    '{mk(ACT_QUERY, 511, 511, 1, 0), 1'b1, res(ST_OK, 2, 4, 4)},
    '{mk(ACT_LOAD, 1, 1, 0, 0), 1'b1, res(ST_OK, 0, 0, 0)},
    '{mk(ACT_QUERY, 0, 0, 0, 0), 1'b1, res(ST_BADQRY, 0, 0, 0)},
    '{mk(ACT_LOAD, 100, 50, 0, 0), 1'b0, '0},
    '{mk(ACT_LOAD, 0, 7, 0, 0), 1'b0, '0},
    '{mk(ACT_LOAD, 200, 50, 0, 0), 1'b0, '0},
    '{mk(ACT_LOAD, 30, 90, 1, 0), 1'b0, '0},
    '{mk(ACT_QUERY, 0, 0, 0, 0), 1'b0, '0},
    '{mk(ACT_QUERY, 0, 0, 0, 1), 1'b0, '0},
    '{mk(ACT_QUERY, 0, 0, 0, 2), 1'b0, '0},
    '{mk(ACT_QUERY, 0, 0, 0, 3), 1'b0, '0},
    '{mk(ACT_QUERY, 0, 0, 0, 4), 1'b0, '0},
    '{mk(ACT_QUERY, 0, 0, 0, 5), 1'b1, res(ST_BADQRY, 0, 0, 0)},
    '{mk(ACT_QUERY, 0, 0, 0, 255), 1'b1, res(ST_BADQRY, 0, 0, 0)}
  };

  int gap_plan [] = '{1, 32, 0, 63, 17, 4};
  int pct_plan [] = '{0, 45, 13, 0, 45, 13};

  initial begin
    gap_now = GapReset;
    n_rects = 0;
    code_now = '0;
    packed_ok = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    for (int p = 0; p < gap_plan.size(); p++) begin
      write_gap(gap_plan[p]);
      idle_pct = pct_plan[p];
      if (gap_plan[p] == 32) begin
        for (int i = 0; i < 60; i++) send_item(mk(ACT_LOAD, 511, 511, i == 59, i));
        send_item(mk(ACT_QUERY, 0, 0, 0, 0));
      end
      if (p == 4) begin
        for (int i = 0; i < Capacity; i++)
          send_item(mk(ACT_LOAD, $urandom_range(1, 12), $urandom_range(0, 12),
                       i == Capacity - 1, 0));
        send_item(mk(ACT_QUERY, 0, 0, 0, 255));
        send_item(mk(ACT_QUERY, 0, 0, 0, 0));
      end
      while (sent < 100 + 120 * (p + 1)) begin
        if ($urandom_range(9) == 0)
          send_item(mk(1'($urandom_range(1)), $urandom_range(511), $urandom_range(511),
                       1'($urandom_range(1)), $urandom_range(255)));
        else
          random_set(($urandom_range(9) == 0) ? $urandom_range(13, 40) :
                     $urandom_range(1, 12), $urandom_range(2));
      end
    end
    // fill the store without closing the set, then overflow it
    idle_pct = 0;
    for (int i = 0; i < Capacity; i++)
      send_item(mk(ACT_LOAD, $urandom_range(511), $urandom_range(511), 1'b0, 0));
    send_item(mk(ACT_LOAD, 5, 5, 1'b0, 0), 1'b1, res(ST_FULL, 0, 0, 0));
    send_item(mk(ACT_LOAD, 511, 511, 1'b1, 0), 1'b1, res(ST_FULL, 0, 0, 0));
    send_item(mk(ACT_QUERY, 0, 0, 0, 0), 1'b1, res(ST_BADQRY, 0, 0, 0));
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/sap_pkg.sv
rtl/core/sap_ram.sv
rtl/core/sap_shelf.sv
rtl/core/shelf_atlas_packer_core.sv
verif/testbench.sv
